>>> hw/rtl/ddd_pkg.sv
// ============================================================================
// Date difference package
// Shared types, constants and calendar tables for the date difference block.
// ============================================================================
package ddd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned PROD_W  = 23;

    // Reciprocal division by one hundred: q = (p * 5243) >> 19, exact for p < 43690.
    localparam int unsigned DIV_W       = 27;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned QUOT_W      = 8;

    localparam logic [YEAR_W-1:0] FIRST_YEAR_RST = 14'd2026;
    localparam logic [YEAR_W-1:0] LAST_YEAR_RST  = 14'd2031;
    localparam logic [YEAR_W-1:0] YEAR_MIN       = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX       = 14'd9999;

    localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

    localparam logic [7:0]  CENTURY     = 8'd100;
    localparam logic [6:0]  CENTURY_END = 7'd99;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [12:0] RECIP_100   = 13'd5243;

    typedef enum logic {
        REG_FIRST_YEAR = 1'b0,
        REG_LAST_YEAR  = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        DN_IDLE,
        DN_DIV,
        DN_SUM
    } t_dn_state;

    typedef enum logic [2:0] {
        STEP_YEARS,
        STEP_QUAD,
        STEP_CENT,
        STEP_QUADCENT,
        STEP_MONTH,
        STEP_LEAP,
        STEP_DAY
    } t_step;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN_FIRST,
        ST_RUN_SECOND,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic done;
        logic real_date;
    } t_dn_stat;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] days;
        case (m)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

>>> hw/rtl/ddd_daynum.sv
// ============================================================================
// Day number unit
// Turns one date into its day number with a reciprocal multiply for the
// division by one hundred and a single shared accumulator, and checks that
// the date is real.
// ============================================================================
module ddd_daynum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ddd_pkg::DAY_W-1:0]    i_day,
    input  logic [ddd_pkg::MONTH_W-1:0]  i_month,
    input  logic [ddd_pkg::YEAR_W-1:0]   i_year,
    output ddd_pkg::t_dn_stat            o_stat,
    output logic [ddd_pkg::COUNT_W-1:0]  o_num
);
    import ddd_pkg::*;

    t_dn_state           r_state, n_state;
    t_step               r_step, n_step;
    t_dn_stat            r_stat, n_stat;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic [YEAR_W-1:0]   r_p, n_p;
    logic [QUOT_W-1:0]   r_q, n_q;
    logic [COUNT_W-1:0]  r_acc, n_acc;

    logic [DIV_W-1:0]    div_prod;
    logic [QUOT_W-1:0]   quot;
    logic [YEAR_W-1:0]   hundreds;
    logic [YEAR_W-1:0]   rem_year;
    logic                cent_year;
    logic                leap;
    logic [DAY_W-1:0]    len;
    logic                date_ok;
    logic [PROD_W-1:0]   product;
    logic [COUNT_W-1:0]  operand;
    logic [COUNT_W-1:0]  base;
    logic                sub;
    logic [COUNT_W-1:0]  sum;

    always_comb begin
        div_prod  = DIV_W'(r_p) * DIV_W'(RECIP_100);
        quot      = div_prod[DIV_W-1:RECIP_SHIFT];
        hundreds  = YEAR_W'(r_q) * YEAR_W'(CENTURY);
        rem_year  = r_p - hundreds;
        cent_year = (rem_year == YEAR_W'(CENTURY_END));
        leap      = (r_year[1:0] == 2'd0) && (!cent_year || ((r_q[1:0] + 2'd1) == 2'd0));
        len       = ((r_month == MONTH_FEB) && leap) ? FEB_LEAP_LEN : month_len(r_month);
        date_ok   = (r_year >= YEAR_MIN) && (r_year <= YEAR_MAX)
                 && (r_month >= MONTH_MIN) && (r_month <= MONTH_MAX)
                 && (r_day >= DAY_MIN) && (r_day <= len);
        product   = PROD_W'(r_p) * PROD_W'(YEAR_DAYS);

        sub  = 1'b0;
        base = r_acc;
        unique case (r_step)
            STEP_YEARS: begin
                base    = '0;
                operand = product[COUNT_W-1:0];
            end
            STEP_QUAD:     operand = COUNT_W'(r_p >> 2);
            STEP_CENT: begin
                sub     = 1'b1;
                operand = COUNT_W'(r_q);
            end
            STEP_QUADCENT: operand = COUNT_W'(r_q >> 2);
            STEP_MONTH:    operand = COUNT_W'(month_start(r_month));
            STEP_LEAP:     operand = COUNT_W'(leap && (r_month > MONTH_FEB));
            STEP_DAY:      operand = COUNT_W'(r_day);
            default:       operand = '0;
        endcase
        sum = base + (operand ^ {COUNT_W{sub}}) + COUNT_W'(sub);
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_stat      = r_stat;
        n_stat.done = 1'b0;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_p         = r_p;
        n_q         = r_q;
        n_acc       = r_acc;
        unique case (r_state)
            DN_IDLE: begin
                if (i_start) begin
                    n_day   = i_day;
                    n_month = i_month;
                    n_year  = i_year;
                    n_p     = i_year - YEAR_MIN;
                    n_q     = '0;
                    n_state = DN_DIV;
                end
            end
            DN_DIV: begin
                n_q     = quot;
                n_step  = STEP_YEARS;
                n_state = DN_SUM;
            end
            DN_SUM: begin
                n_acc = sum;
                if (r_step == STEP_DAY) begin
                    n_stat.done      = 1'b1;
                    n_stat.real_date = date_ok;
                    n_state          = DN_IDLE;
                end else begin
                    n_step = t_step'(r_step + 3'd1);
                end
            end
            default: n_state = DN_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DN_IDLE;
            r_stat  <= '0;
        end else begin
            r_state <= n_state;
            r_stat  <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        r_p     <= n_p;
        r_q     <= n_q;
        r_acc   <= n_acc;
    end

    assign o_stat = r_stat;
    assign o_num  = r_acc;

endmodule

>>> hw/rtl/date_difference_in_days.sv
// ============================================================================
// Date difference in days
// Counts the days between two Gregorian dates and checks each date against
// the calendar and a configurable window of years.
// ============================================================================
//  Channel  Signals                          Direction  Payload
//  in       i_in_valid / o_in_ready          sink       two dates
//  out      o_out_valid / i_out_ready        source     count and flags
//  cfg      i_cfg_we, i_cfg_idx, i_cfg_wdata sink       year window
//
//  The block is not ready again from acceptance until the result is loaded
//  into the output register. Each date passes through the day number unit
//  once: a start pulse, one reciprocal multiply for the division by one
//  hundred, 7 accumulator steps and a registered capture of its day number.
//  Reset is synchronous and restores the window to 2026 through 2031.
//  A result waiting in the output register stalls only the final step.
// ============================================================================
module date_difference_in_days (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [ddd_pkg::YEAR_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ddd_pkg::DAY_W-1:0]    i_first_day,
    input  logic [ddd_pkg::MONTH_W-1:0]  i_first_month,
    input  logic [ddd_pkg::YEAR_W-1:0]   i_first_year_req,
    input  logic [ddd_pkg::DAY_W-1:0]    i_second_day,
    input  logic [ddd_pkg::MONTH_W-1:0]  i_second_month,
    input  logic [ddd_pkg::YEAR_W-1:0]   i_second_year,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ddd_pkg::COUNT_W-1:0]  o_day_count,
    output logic                         o_dates_real,
    output logic                         o_first_in_window,
    output logic                         o_second_in_window
);
    import ddd_pkg::*;

    t_state              r_state, n_state;
    logic                r_start, n_start;
    logic                r_sel, n_sel;
    logic [YEAR_W-1:0]   r_first_year, n_first_year;
    logic [YEAR_W-1:0]   r_last_year, n_last_year;
    logic [DAY_W-1:0]    r_fd, n_fd;
    logic [MONTH_W-1:0]  r_fm, n_fm;
    logic [YEAR_W-1:0]   r_fy, n_fy;
    logic [DAY_W-1:0]    r_sd, n_sd;
    logic [MONTH_W-1:0]  r_sm, n_sm;
    logic [YEAR_W-1:0]   r_sy, n_sy;
    logic [COUNT_W-1:0]  r_n1, n_n1;
    logic [COUNT_W-1:0]  r_n2, n_n2;
    logic                r_real1, n_real1;
    logic                r_real2, n_real2;
    logic                r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_real, n_real;
    logic                r_win1, n_win1;
    logic                r_win2, n_win2;

    t_dn_stat            dn_stat;
    logic [COUNT_W-1:0]  dn_num;
    logic                gt;
    logic [COUNT_W-1:0]  big;
    logic [COUNT_W-1:0]  little;
    logic [COUNT_W-1:0]  diff;

    ddd_daynum u_daynum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_day   (r_sel ? r_sd : r_fd),
        .i_month (r_sel ? r_sm : r_fm),
        .i_year  (r_sel ? r_sy : r_fy),
        .o_stat  (dn_stat),
        .o_num   (dn_num)
    );

    always_comb begin
        gt     = (r_n1 > r_n2);
        big    = gt ? r_n1 : r_n2;
        little = gt ? r_n2 : r_n1;
        diff   = big - little;
    end

    always_comb begin
        n_state      = r_state;
        n_start      = 1'b0;
        n_sel        = r_sel;
        n_first_year = r_first_year;
        n_last_year  = r_last_year;
        n_fd         = r_fd;
        n_fm         = r_fm;
        n_fy         = r_fy;
        n_sd         = r_sd;
        n_sm         = r_sm;
        n_sy         = r_sy;
        n_n1         = r_n1;
        n_n2         = r_n2;
        n_real1      = r_real1;
        n_real2      = r_real2;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_count      = r_count;
        n_real       = r_real;
        n_win1       = r_win1;
        n_win2       = r_win2;

        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_FIRST_YEAR: n_first_year = i_cfg_wdata;
                REG_LAST_YEAR:  n_last_year  = i_cfg_wdata;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_fd    = i_first_day;
                    n_fm    = i_first_month;
                    n_fy    = i_first_year_req;
                    n_sd    = i_second_day;
                    n_sm    = i_second_month;
                    n_sy    = i_second_year;
                    n_sel   = 1'b0;
                    n_start = 1'b1;
                    n_state = ST_RUN_FIRST;
                end
            end
            ST_RUN_FIRST: begin
                if (dn_stat.done) begin
                    n_n1    = dn_num;
                    n_real1 = dn_stat.real_date;
                    n_sel   = 1'b1;
                    n_start = 1'b1;
                    n_state = ST_RUN_SECOND;
                end
            end
            ST_RUN_SECOND: begin
                if (dn_stat.done) begin
                    n_n2    = dn_num;
                    n_real2 = dn_stat.real_date;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_real      = r_real1 && r_real2;
                    n_count     = (r_real1 && r_real2) ? diff : '0;
                    n_win1      = r_real1 && (r_fy >= r_first_year) && (r_fy <= r_last_year);
                    n_win2      = r_real2 && (r_sy >= r_first_year) && (r_sy <= r_last_year);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_first_year <= FIRST_YEAR_RST;
            r_last_year  <= LAST_YEAR_RST;
        end else begin
            r_state      <= n_state;
            r_start      <= n_start;
            r_out_valid  <= n_out_valid;
            r_first_year <= n_first_year;
            r_last_year  <= n_last_year;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel   <= n_sel;
        r_fd    <= n_fd;
        r_fm    <= n_fm;
        r_fy    <= n_fy;
        r_sd    <= n_sd;
        r_sm    <= n_sm;
        r_sy    <= n_sy;
        r_n1    <= n_n1;
        r_n2    <= n_n2;
        r_real1 <= n_real1;
        r_real2 <= n_real2;
        r_count <= n_count;
        r_real  <= n_real;
        r_win1  <= n_win1;
        r_win2  <= n_win2;
    end

    assign o_in_ready         = (r_state == ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_day_count        = r_count;
    assign o_dates_real       = r_real;
    assign o_first_in_window  = r_win1;
    assign o_second_in_window = r_win2;

endmodule

>>> hw/rtl/ddd_checker.sv
// ============================================================================
// Date difference checker
// Port-level assertions for the date difference block, bound to its top level.
// ============================================================================
module ddd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_ready,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  logic [ddd_pkg::COUNT_W-1:0]  o_day_count,
    input  logic                         o_dates_real,
    input  logic                         o_first_in_window,
    input  logic                         o_second_in_window
);
    import ddd_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd3652058;

    // A result held back by the consumer keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_day_count))
        else $error("output changed while stalled");

    // The block is busy for the cycle after it takes a transaction.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a transaction was accepted");

    // When either date is unreal the count is zero.
    a_unreal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_dates_real |-> (o_day_count == '0))
        else $error("nonzero count for an unreal date");

    // Both window flags imply that both dates are real.
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_first_in_window && o_second_in_window |-> o_dates_real)
        else $error("window flags set without real dates");

    // The count never exceeds the span of the calendar.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_day_count <= COUNT_MAX))
        else $error("count out of range");

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (.*);
